/* sv/key_entry_with_timeout_warning_core_defines.svh */
// assertion macros for the key entry core
`ifndef KEY_ENTRY_WITH_TIMEOUT_WARNING_CORE_DEFINES_SVH
`define KEY_ENTRY_WITH_TIMEOUT_WARNING_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KEWT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define KEWT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KEWT_ASSERT_NOW(lbl, ante, cons, msg)
`define KEWT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/kewt_pkg.sv */
// shared types and constants for the key entry core
`default_nettype none
package kewt_pkg;

	localparam int MAX_KEY_CHARS_DEF = 8;
	localparam int KEY_BYTES_W       = 64;
	localparam int CFG_INDEX_W       = 3;
	localparam int CFG_DATA_W        = 16;

	localparam logic [15:0] FIRST_WARNING_RST = 16'd10000;
	localparam logic [15:0] SECOND_WARNING_RST = 16'd30000;
	localparam logic [15:0] FAIL_RST          = 16'd45000;
	localparam logic [15:0] BLINK_PERIOD_RST  = 16'd500;
	localparam logic [3:0]  MIN_KEY_LEN_RST   = 4'd1;

	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_TICK  = 2'd1,
		OP_BYTE  = 2'd2,
		OP_RXERR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_COLLECTING = 2'd0,
		ST_COMPLETE   = 2'd1,
		ST_TIMEOUT    = 2'd2,
		ST_RXFAIL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		STG_NONE  = 2'd0,
		STG_FIRST = 2'd1,
		STG_BLINK = 2'd2,
		STG_DONE  = 2'd3
	} stage_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FIRST_WARNING  = 3'd0,
		CFG_SECOND_WARNING = 3'd1,
		CFG_FAIL           = 3'd2,
		CFG_BLINK_PERIOD   = 3'd3,
		CFG_MIN_KEY_LEN    = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [15:0] first_warning_ms;
		logic [15:0] second_warning_ms;
		logic [15:0] fail_ms;
		logic [15:0] blink_period_ms;
		logic [3:0]  min_key_length;
	} cfg_t;

	// one item as it leaves the input register, already gated
	typedef struct packed {
		logic       start;
		logic       tick;
		logic       byte_en;
		logic [7:0] rx_byte;
	} step_t;

	typedef struct packed {
		logic   led;
		stage_t stage;
		logic   timeout;
	} timer_view_t;

	typedef struct packed {
		logic [3:0]             count;
		logic [KEY_BYTES_W-1:0] key_bytes;
		logic                   complete;
	} key_view_t;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage
`default_nettype wire

/* sv/kewt_cfg_regs.sv */
// configuration registers with their reset values
`default_nettype none
module kewt_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [kewt_pkg::CFG_INDEX_W-1:0] wr_index,
	input  wire logic [kewt_pkg::CFG_DATA_W-1:0]  wr_data,
	output kewt_pkg::cfg_t                        cfg
);

	kewt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_warning_ms  <= kewt_pkg::FIRST_WARNING_RST;
			cfg_q.second_warning_ms <= kewt_pkg::SECOND_WARNING_RST;
			cfg_q.fail_ms           <= kewt_pkg::FAIL_RST;
			cfg_q.blink_period_ms   <= kewt_pkg::BLINK_PERIOD_RST;
			cfg_q.min_key_length    <= kewt_pkg::MIN_KEY_LEN_RST;
		end else if (wr_en) begin
			case (kewt_pkg::cfg_index_t'(wr_index))
				kewt_pkg::CFG_FIRST_WARNING:  cfg_q.first_warning_ms  <= wr_data;
				kewt_pkg::CFG_SECOND_WARNING: cfg_q.second_warning_ms <= wr_data;
				kewt_pkg::CFG_FAIL:           cfg_q.fail_ms           <= wr_data;
				kewt_pkg::CFG_BLINK_PERIOD:   cfg_q.blink_period_ms   <= wr_data;
				kewt_pkg::CFG_MIN_KEY_LEN:    cfg_q.min_key_length    <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* sv/kewt_warn_timer.sv */
// elapsed counter and warning stage / led sequencing
`default_nettype none
module kewt_warn_timer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire kewt_pkg::cfg_t  cfg,
	input  wire kewt_pkg::step_t step,
	output kewt_pkg::timer_view_t view
);

	logic [15:0]      elapsed_q, elapsed_n;
	logic [15:0]      last_toggle_q, last_toggle_n;
	logic             led_q, led_n;
	kewt_pkg::stage_t stage_q, stage_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q     <= '0;
			last_toggle_q <= '0;
			led_q         <= 1'b0;
			stage_q       <= kewt_pkg::STG_NONE;
		end else begin
			elapsed_q     <= elapsed_n;
			last_toggle_q <= last_toggle_n;
			led_q         <= led_n;
			stage_q       <= stage_n;
		end
	end

	always_comb begin
		logic [15:0] since_toggle;
		elapsed_n     = elapsed_q;
		last_toggle_n = last_toggle_q;
		led_n         = led_q;
		stage_n       = stage_q;
		since_toggle  = '0;
		if (step.start) begin
			elapsed_n     = '0;
			last_toggle_n = '0;
			led_n         = 1'b0;
			stage_n       = kewt_pkg::STG_NONE;
		end else if (step.tick) begin
			// saturating count
			if (elapsed_q != 16'hFFFF) begin
				elapsed_n = elapsed_q + 16'd1;
			end
			since_toggle = elapsed_n - last_toggle_q;
			case (stage_q)
				kewt_pkg::STG_NONE: begin
					if (elapsed_n >= cfg.first_warning_ms) begin
						led_n   = 1'b1;
						stage_n = kewt_pkg::STG_FIRST;
					end
				end
				kewt_pkg::STG_FIRST: begin
					if (elapsed_n >= cfg.second_warning_ms) begin
						stage_n = kewt_pkg::STG_BLINK;
					end
				end
				kewt_pkg::STG_BLINK: begin
					if (since_toggle >= cfg.blink_period_ms) begin
						led_n         = ~led_q;
						last_toggle_n = elapsed_n;
					end
					// fail threshold overrides the blink toggle
					if (elapsed_n >= cfg.fail_ms) begin
						led_n   = 1'b0;
						stage_n = kewt_pkg::STG_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	assign view.led     = led_n;
	assign view.stage   = stage_n;
	assign view.timeout = step.tick && (stage_n == kewt_pkg::STG_DONE);

endmodule
`default_nettype wire

/* sv/kewt_key_buf.sv */
// key character store, count and newline completion
`default_nettype none
module kewt_key_buf #(
	parameter int MAX_KEY_CHARS = kewt_pkg::MAX_KEY_CHARS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [3:0] min_key_length,
	input  wire kewt_pkg::step_t step,
	output kewt_pkg::key_view_t view
);

	localparam int IDX_W = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;

	logic [7:0] store_q [MAX_KEY_CHARS];
	logic [7:0] store_n [MAX_KEY_CHARS];
	logic [3:0] count_q, count_n;
	logic       complete;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < MAX_KEY_CHARS; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			count_q <= count_n;
			for (int i = 0; i < MAX_KEY_CHARS; i++) begin
				store_q[i] <= store_n[i];
			end
		end
	end

	always_comb begin
		store_n  = store_q;
		count_n  = count_q;
		complete = 1'b0;
		if (step.start) begin
			count_n = '0;
			for (int i = 0; i < MAX_KEY_CHARS; i++) begin
				store_n[i] = '0;
			end
		end else if (step.byte_en) begin
			if (step.rx_byte == kewt_pkg::CHAR_LF && count_q >= min_key_length) begin
				complete = 1'b1;
			end else if (count_q < 4'(MAX_KEY_CHARS) && kewt_pkg::is_alnum(step.rx_byte)) begin
				store_n[count_q[IDX_W-1:0]] = step.rx_byte;
				count_n = count_q + 4'd1;
			end
		end
	end

	always_comb begin
		view.key_bytes = '0;
		for (int i = 0; i < MAX_KEY_CHARS; i++) begin
			view.key_bytes[i*8 +: 8] = store_n[i];
		end
		view.count    = count_n;
		view.complete = complete;
	end

endmodule
`default_nettype wire

/* sv/key_entry_with_timeout_warning_core.sv */
// Key entry with timeout warning: one result for each input transaction.
// A result passes through the input register (s1), then the result register;
// state updates in the same cycle the item leaves s1.
// Throughput: one item per cycle, limited only by the result register handoff.
// Reset (arst_n low, asynchronous): registers back to defaults, entry cleared.
`default_nettype none
`include "key_entry_with_timeout_warning_core_defines.svh"
module key_entry_with_timeout_warning_core #(
	parameter int MAX_KEY_CHARS = kewt_pkg::MAX_KEY_CHARS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
	input  wire logic [1:0]                       s_axis_tuser,  // [1:0] operation
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [1:0] status, [2] warning_led, [4:3] warning_stage, [8:5] key_length,
	// [72:9] key_bytes, [79:73] zero
	output logic [79:0]                           m_axis_tdata,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [kewt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [kewt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	kewt_pkg::cfg_t        cfg;
	kewt_pkg::step_t       step;
	kewt_pkg::timer_view_t tview;
	kewt_pkg::key_view_t   kview;

	logic             valid_s1;
	kewt_pkg::op_t    op_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             collecting;
	kewt_pkg::status_t outcome_q, outcome_n;
	logic             m_valid_q;
	logic [79:0]      m_data_q;

	assign cfg_ready = 1'b1;

	kewt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// s1 moves on when the result register is free or being emptied
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= kewt_pkg::op_t'(s_axis_tuser);
			byte_s1 <= s_axis_tdata;
		end
	end

	assign collecting   = (outcome_q == kewt_pkg::ST_COLLECTING);
	assign step.start   = advance && (op_s1 == kewt_pkg::OP_START);
	assign step.tick    = advance && collecting && (op_s1 == kewt_pkg::OP_TICK);
	assign step.byte_en = advance && collecting && (op_s1 == kewt_pkg::OP_BYTE);
	assign step.rx_byte = byte_s1;

	kewt_warn_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.view   (tview)
	);

	kewt_key_buf #(
		.MAX_KEY_CHARS (MAX_KEY_CHARS)
	) u_key (
		.clk            (clk),
		.arst_n         (arst_n),
		.min_key_length (cfg.min_key_length),
		.step           (step),
		.view           (kview)
	);

	always_comb begin
		outcome_n = outcome_q;
		if (step.start) begin
			outcome_n = kewt_pkg::ST_COLLECTING;
		end else if (advance && collecting) begin
			case (op_s1)
				kewt_pkg::OP_TICK:  if (tview.timeout) outcome_n = kewt_pkg::ST_TIMEOUT;
				kewt_pkg::OP_BYTE:  if (kview.complete) outcome_n = kewt_pkg::ST_COMPLETE;
				kewt_pkg::OP_RXERR: outcome_n = kewt_pkg::ST_RXFAIL;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outcome_q <= kewt_pkg::ST_COLLECTING;
			m_valid_q <= 1'b0;
		end else begin
			outcome_q <= outcome_n;
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {7'd0, kview.key_bytes, kview.count, tview.stage, tview.led,
				outcome_n};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	`KEWT_ASSERT_NEXT(a_s1_held, valid_s1 && !advance, valid_s1, "s1 item lost while stalled")
	`KEWT_ASSERT_NOW(a_done_means_timeout,
		m_valid_q && (m_data_q[4:3] == kewt_pkg::STG_DONE),
		(m_data_q[1:0] == kewt_pkg::ST_TIMEOUT) && !m_data_q[2],
		"timeout stage without timeout status or with led lit")
	`KEWT_ASSERT_NOW(a_key_len_bound, m_valid_q,
		m_data_q[8:5] <= 4'(MAX_KEY_CHARS), "key length beyond store depth")
	`KEWT_ASSERT_NEXT(a_finished_holds,
		advance && !collecting && (op_s1 != kewt_pkg::OP_START),
		outcome_q == $past(outcome_q), "finished entry changed without start")

endmodule
`default_nettype wire

/* verif/key_entry_with_timeout_warning_core_test.sv */
// self-checking testbench for the key entry core with timeout warning
module key_entry_with_timeout_warning_core_test;
	import kewt_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	// keeps its own copy of the entry state and registers, predicts every result
	class key_entry_scoreboard;
		logic [15:0] first_ms, second_ms, fail_lim, blink_ms;
		logic [3:0]  min_len;
		logic [15:0] elapsed, toggled_at;
		stage_t      stg;
		logic        led;
		logic [63:0] key_word;
		logic [3:0]  count;
		status_t     outcome;
		logic [79:0] expected_q [$];
		int          errors;

		function new();
			first_ms = FIRST_WARNING_RST;
			second_ms = SECOND_WARNING_RST;
			fail_lim = FAIL_RST;
			blink_ms = BLINK_PERIOD_RST;
			min_len = MIN_KEY_LEN_RST;
			errors = 0;
			clear_entry();
		endfunction

		function void clear_entry();
			elapsed = '0;
			toggled_at = '0;
			stg = STG_NONE;
			led = 1'b0;
			key_word = '0;
			count = '0;
			outcome = ST_COLLECTING;
		endfunction

		function logic is_key_char(logic [7:0] c);
			return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_FIRST_WARNING: first_ms = data;
				CFG_SECOND_WARNING: second_ms = data;
				CFG_FAIL: fail_lim = data;
				CFG_BLINK_PERIOD: blink_ms = data;
				CFG_MIN_KEY_LEN: min_len = data[3:0];
				default: ;
			endcase
		endfunction

		function void note_input(op_t op, logic [7:0] b);
			logic [15:0] since_toggle;
			if (op == OP_START) begin
				clear_entry();
			end else if (outcome == ST_COLLECTING) begin
				case (op)
					OP_TICK: begin
						if (elapsed != 16'hFFFF)
							elapsed = elapsed + 16'd1;
						case (stg)
							STG_NONE: begin
								if (elapsed >= first_ms) begin
									led = 1'b1;
									stg = STG_FIRST;
								end
							end
							STG_FIRST: begin
								if (elapsed >= second_ms)
									stg = STG_BLINK;
							end
							STG_BLINK: begin
								since_toggle = elapsed - toggled_at;
								if (since_toggle >= blink_ms) begin
									led = ~led;
									toggled_at = elapsed;
								end
								if (elapsed >= fail_lim) begin
									led = 1'b0;
									stg = STG_DONE;
								end
							end
							default: ;
						endcase
						if (stg == STG_DONE)
							outcome = ST_TIMEOUT;
					end
					OP_BYTE: begin
						if (b == CHAR_LF && count >= min_len) begin
							outcome = ST_COMPLETE;
						end else if (count < MAX_KEY_CHARS_DEF && is_key_char(b)) begin
							key_word[count*8 +: 8] = b;
							count = count + 4'd1;
						end
					end
					default: outcome = ST_RXFAIL;
				endcase
			end
			expected_q.push_back({7'd0, key_word, count, stg, led, outcome});
		endfunction

		function void compare_field(string label, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [79:0] got);
			logic [79:0] want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: expected none, actual %0h",
					$time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("status", 64'(want[1:0]), 64'(got[1:0]));
			compare_field("warning_led", 64'(want[2]), 64'(got[2]));
			compare_field("warning_stage", 64'(want[4:3]), 64'(got[4:3]));
			compare_field("key_length", 64'(want[8:5]), 64'(got[8:5]));
			compare_field("key_bytes", want[72:9], got[72:9]);
			compare_field("padding", 64'(want[79:73]), 64'(got[79:73]));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;   // [7:0] rx_byte
	logic [1:0] s_axis_tuser = '0;   // [1:0] operation
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// [1:0] status, [2] warning_led, [4:3] warning_stage, [8:5] key_length,
	// [72:9] key_bytes, [79:73] zero
	logic [79:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	key_entry_scoreboard sb;
	int unsigned cycles = 0;
	int burst_left = 0;
	int items_sent = 0;
	logic [31:0] ready_pattern = '1;
	logic [6:0] pattern_pos = '0;

	key_entry_with_timeout_warning_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stall pattern, renewed each time pattern_pos wraps to zero
	always @(posedge clk) begin
		if (pattern_pos == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern = '1;
				1: ready_pattern = $urandom;
				2: ready_pattern = $urandom | $urandom;
				default: ready_pattern = $urandom & $urandom;
			endcase
		end
		m_axis_tready <= ready_pattern[pattern_pos[4:0]];
		pattern_pos <= pattern_pos + 7'd1;
	end

	// results are checked before the input of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input(op_t'(s_axis_tuser), s_axis_tdata);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	task automatic send_item(input op_t op, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		items_sent++;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input logic [15:0] fw, input logic [15:0] sw,
			input logic [15:0] fl, input logic [15:0] bl, input logic [15:0] ml);
		cfg_write(CFG_FIRST_WARNING, fw);
		cfg_write(CFG_SECOND_WARNING, sw);
		cfg_write(CFG_FAIL, fl);
		cfg_write(CFG_BLINK_PERIOD, bl);
		cfg_write(CFG_MIN_KEY_LEN, ml);
		// unmapped indexes must not disturb anything
		if ($urandom_range(0, 3) == 0)
			cfg_write(CFG_INDEX_W'($urandom_range(5, 7)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_key_char();
		int k;
		k = $urandom_range(0, 61);
		if (k < 10)
			return 8'(8'h30 + k);
		else if (k < 36)
			return 8'(8'h41 + k - 10);
		return 8'(8'h61 + k - 36);
	endfunction

	task automatic run_entry(input int len);
		int r;
		send_item(OP_START, 8'($urandom));
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 48)
				send_item(OP_TICK, 8'($urandom));
			else if (r < 92) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					send_item(OP_BYTE, pick_key_char());
				else if (r < 75)
					send_item(OP_BYTE, CHAR_LF);
				else
					send_item(OP_BYTE, 8'($urandom));
			end else if (r < 96)
				send_item(OP_RXERR, 8'($urandom));
			else
				send_item(OP_START, 8'($urandom));
		end
	endtask

	initial begin
		logic [7:0] boundary_chars [16];
		logic [15:0] fw, sw, fl, bl, ml;
		int target;
		sb = new();
		boundary_chars = '{8'h30, 8'h39, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h2F, 8'h3A,
			8'h40, 8'h5B, 8'h60, 8'h7B, 8'h6D, 8'h51, 8'h35, 8'h37};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// items before any start act on the reset state
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'h61);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, CHAR_LF);
		// finished entry ignores everything but start
		send_item(OP_TICK, 8'hFF);
		send_item(OP_RXERR, 8'h5A);
		send_item(OP_BYTE, 8'h62);
		send_item(OP_START, 8'hA5);
		// range edges of letters and digits, neighbors, and overflow past eight
		foreach (boundary_chars[i])
			send_item(OP_BYTE, boundary_chars[i]);
		send_item(OP_BYTE, CHAR_LF);
		send_item(OP_START, 8'h00);
		send_item(OP_RXERR, 8'h00);
		drain_results();

		// all thresholds zero, empty key accepted
		program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFF0);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, CHAR_LF);
		send_item(OP_START, 8'h00);
		repeat (4) send_item(OP_TICK, 8'h00);
		drain_results();

		// blink period zero toggles every tick; full-length minimum
		program_regs(16'd2, 16'd4, 16'd20, 16'd0, 16'd8);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, CHAR_LF);
		repeat (8) send_item(OP_BYTE, pick_key_char());
		send_item(OP_BYTE, CHAR_LF);
		send_item(OP_START, 8'h00);
		repeat (22) send_item(OP_TICK, 8'h00);
		drain_results();

		// upper extremes; minimum above eight never completes
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h000F);
		send_item(OP_START, 8'h00);
		repeat (9) send_item(OP_BYTE, pick_key_char());
		send_item(OP_BYTE, CHAR_LF);
		send_item(OP_TICK, 8'h00);
		send_item(OP_RXERR, 8'h00);
		drain_results();

		target = items_sent + 1250;
		while (items_sent < target) begin
			case ($urandom_range(0, 7))
				0: begin
					fw = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
					sw = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
					fl = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
					bl = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
				end
				1: begin
					fw = 16'($urandom_range(0, 30));
					sw = 16'($urandom_range(0, 30));
					fl = 16'($urandom_range(0, 40));
					bl = 16'($urandom_range(0, 8));
				end
				default: begin
					fw = 16'($urandom_range(0, 15));
					sw = fw + 16'($urandom_range(0, 20));
					fl = sw + 16'($urandom_range(0, 25));
					bl = 16'($urandom_range(0, 6));
				end
			endcase
			ml = (16'($urandom) & 16'hFFF0) |
				16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8));
			program_regs(fw, sw, fl, bl, ml);
			repeat ($urandom_range(2, 5))
				run_entry($urandom_range(5, 80));
			drain_results();
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/kewt_pkg.sv
sv/kewt_cfg_regs.sv
sv/kewt_warn_timer.sv
sv/kewt_key_buf.sv
sv/key_entry_with_timeout_warning_core.sv
verif/key_entry_with_timeout_warning_core_test.sv
